>>> rtl/phase_angle_dimmer_4ch_unit_assert.svh
// assertion macros for the phase angle dimmer block
// no dependencies; included by the top level only
`ifndef PHASE_ANGLE_DIMMER_4CH_UNIT_ASSERT_SVH
`define PHASE_ANGLE_DIMMER_4CH_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// checked property, idle while reset is held
`define PAD4_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pad4 assertion failed");

// checked property, also active during reset
`define PAD4_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pad4 assertion failed");

`else

`define PAD4_ASSERT(lbl, clk, rst_n, prop)
`define PAD4_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> rtl/pad4_pkg.sv
// shared constants, codes and types of the phase angle dimmer
// no dependencies
package pad4_pkg;

  localparam int CHANNELS   = 4;
  localparam int CH_W       = $clog2(CHANNELS);
  localparam int OP_W       = 2;
  localparam int CTL_W      = 7;
  localparam int VAL_W      = 7;
  localparam int LEVEL_W    = 8;
  localparam int PHASE_W    = 8;
  localparam int DIV_W      = 8;
  localparam int FS_W       = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [LEVEL_W-1:0] LEVEL_OFF      = 8'h80;
  localparam logic [PHASE_W-1:0] PHASE_MAX      = 8'hFF;
  localparam logic [FS_W-1:0]    FULL_SCALE_RST = 7'd110;
  localparam logic [DIV_W-1:0]   KHZ_DIV_RST    = 8'd18;

  // item operation codes
  typedef enum logic [OP_W-1:0] {
    OP_TICK        = 2'd0,
    OP_ZERO_CROSS  = 2'd1,
    OP_CTRL_CHANGE = 2'd2
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FULL_SCALE = 2'd0,
    CFG_KHZ_DIVIDE = 2'd1
  } cfg_idx_t;

  // per-item command to the channel bank
  typedef struct packed {
    logic               tick;
    logic               zero_cross;
    logic               ctrl_change;
    logic [CH_W-1:0]    chan;
    logic [LEVEL_W-1:0] level;
    logic [PHASE_W-1:0] phase_nxt;
  } bank_cmd_t;

  // level = 128 - dim, dim clamped at zero
  function automatic logic [LEVEL_W-1:0] level_of(input logic [VAL_W-1:0] value,
                                                  input logic [FS_W-1:0] full_scale);
    logic [FS_W-1:0] dim;
    dim = (value > full_scale) ? '0 : FS_W'(full_scale - value);
    return LEVEL_W'(LEVEL_OFF - {1'b0, dim});
  endfunction

endpackage

>>> rtl/pad4_if.sv
// channel interfaces: input items, result items, configuration writes
// depends on pad4_pkg
interface pad4_in_if;
  import pad4_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [CTL_W-1:0] controller;
  logic [VAL_W-1:0] value;
  modport source (output valid, operation, controller, value, input ready);
  modport sink   (input valid, operation, controller, value, output ready);
endinterface

interface pad4_out_if;
  import pad4_pkg::*;
  logic                valid;
  logic                ready;
  logic [CHANNELS-1:0] lamp_drive;
  logic                slow_pulse;
  logic                clock_out;
  modport source (output valid, lamp_drive, slow_pulse, clock_out, input ready);
  modport sink   (input valid, lamp_drive, slow_pulse, clock_out, output ready);
endinterface

interface pad4_cfg_if;
  import pad4_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/phase_angle_dimmer_4ch_unit.sv
// top level of the four channel phase angle dimmer
// depends on pad4_pkg, pad4_if, pad4_chan_bank and the assertion header
//
//  port     dir   contents
//  in_ch    sink  operation, controller, value
//  out_ch   src   lamp_drive, slow_pulse, clock_out
//  cfg_ch   sink  index, data (full_scale, khz_divide)
//
// state and result register load on the input transfer
// results appear in the cycle after the transfer; an item can follow every cycle unless a result is stalled
// a stalled result holds in_ch.ready low only while out_ch.ready is low
// synchronous active low reset clears counters, levels to off, drive bits
// configuration writes are always taken (cfg_ch.ready is tied high)
`include "phase_angle_dimmer_4ch_unit_assert.svh"

module phase_angle_dimmer_4ch_unit (
  input  logic        clk,
  input  logic        rst_n,
  pad4_in_if.sink     in_ch,
  pad4_out_if.source  out_ch,
  pad4_cfg_if.sink    cfg_ch
);
  import pad4_pkg::*;

  logic [FS_W-1:0]     full_scale_r;
  logic [DIV_W-1:0]    khz_div_r;
  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  logic [DIV_W-1:0]    div_r, div_nxt, div_inc;
  logic                clock_r, clock_nxt;
  logic                out_valid_r;
  logic [CHANNELS-1:0] lamp_r;
  logic                slow_r, clko_r;
  logic [CHANNELS-1:0] drive_nxt;
  logic                in_xfer, tick, zc, cc, pulse;
  bank_cmd_t           cmd;

  // input transfer decode
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign tick = in_xfer && (in_ch.operation == OP_TICK);
  assign zc   = in_xfer && (in_ch.operation == OP_ZERO_CROSS);
  assign cc   = in_xfer && (in_ch.operation == OP_CTRL_CHANGE);

  // configuration writes
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_scale_r <= FULL_SCALE_RST;
      khz_div_r    <= KHZ_DIV_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_FULL_SCALE: full_scale_r <= cfg_ch.data[FS_W-1:0];
        CFG_KHZ_DIVIDE: khz_div_r    <= cfg_ch.data[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // phase counter, saturating on tick, cleared on zero cross
  always_comb begin
    phase_nxt = phase_r;
    if (tick && (phase_r != PHASE_MAX)) begin
      phase_nxt = PHASE_W'(phase_r + 1'b1);
    end else if (zc) begin
      phase_nxt = '0;
    end
  end

  // tick divider and clock toggle
  assign div_inc   = DIV_W'(div_r + 1'b1);
  assign pulse     = tick && (div_inc == khz_div_r);
  assign div_nxt   = !tick ? div_r : (pulse ? '0 : div_inc);
  assign clock_nxt = clock_r ^ tick;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      div_r   <= '0;
      clock_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      div_r   <= div_nxt;
      clock_r <= clock_nxt;
    end
  end

  // channel bank command
  always_comb begin
    cmd.tick        = tick;
    cmd.zero_cross  = zc;
    cmd.ctrl_change = cc;
    cmd.chan        = in_ch.controller[CH_W-1:0];
    cmd.level       = level_of(in_ch.value, full_scale_r);
    cmd.phase_nxt   = phase_nxt;
  end

  pad4_chan_bank u_bank (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .drive_nxt (drive_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      lamp_r <= drive_nxt;
      slow_r <= pulse;
      clko_r <= clock_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.lamp_drive = lamp_r;
  assign out_ch.slow_pulse = slow_r;
  assign out_ch.clock_out  = clko_r;

  // checks
  `PAD4_ASSERT(a_xfer_gives_result, clk, rst_n, in_xfer |=> out_valid_r)
  `PAD4_ASSERT(a_zc_clears_phase, clk, rst_n, zc |=> (phase_r == '0))
  `PAD4_ASSERT(a_tick_toggles, clk, rst_n, tick |=> (clock_r != $past(clock_r)))
  `PAD4_ASSERT(a_pulse_only_tick, clk, rst_n, (in_xfer && !tick) |=> !slow_r)

endmodule

>>> rtl/pad4_chan_bank.sv
// channel levels and gate drive bits, with the per-channel compares
// depends on pad4_pkg
module pad4_chan_bank (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pad4_pkg::bank_cmd_t          cmd,
  output logic [pad4_pkg::CHANNELS-1:0] drive_nxt
);
  import pad4_pkg::*;

  logic [LEVEL_W-1:0]  level_r [CHANNELS];
  logic [CHANNELS-1:0] drive_r;

  // gate update: tick turns on past the level, zero cross turns off channels whose level is nonzero
  always_comb begin
    drive_nxt = drive_r;
    for (int k = 0; k < CHANNELS; k++) begin
      if (cmd.tick && (level_r[k] < cmd.phase_nxt)) begin
        drive_nxt[k] = 1'b1;
      end
      if (cmd.zero_cross && (level_r[k] != '0)) begin
        drive_nxt[k] = 1'b0;
      end
    end
  end

  // level and drive state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r <= '0;
      for (int k = 0; k < CHANNELS; k++) begin
        level_r[k] <= LEVEL_OFF;
      end
    end else begin
      drive_r <= drive_nxt;
      if (cmd.ctrl_change) begin
        level_r[cmd.chan] <= cmd.level;
      end
    end
  end

endmodule
